// File: hw/rtl/psp_pkg.sv
// ----------------------------------------------------------------------------
// psp_pkg
// shared types, character codes and helpers for the printf spec parser
// ----------------------------------------------------------------------------
package psp_pkg;

  localparam logic [31:0] NUM_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] PREC_NONE = 32'hFFFF_FFFF;

  // format characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UC    = 8'h43;
  localparam logic [7:0] CH_UL    = 8'h4C;
  localparam logic [7:0] CH_US    = 8'h53;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LC    = 8'h63;
  localparam logic [7:0] CH_LD    = 8'h64;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LH    = 8'h68;
  localparam logic [7:0] CH_LI    = 8'h69;
  localparam logic [7:0] CH_LL    = 8'h6C;
  localparam logic [7:0] CH_LO    = 8'h6F;
  localparam logic [7:0] CH_LP    = 8'h70;
  localparam logic [7:0] CH_LS    = 8'h73;
  localparam logic [7:0] CH_LU    = 8'h75;
  localparam logic [7:0] CH_LX    = 8'h78;

  typedef enum logic [2:0] {
    LEN_NONE = 3'd0,
    LEN_H    = 3'd1,
    LEN_HH   = 3'd2,
    LEN_L    = 3'd3,
    LEN_LL   = 3'd4
  } len_code_t;

  typedef enum logic [1:0] {
    NUM_OFF   = 2'd0,
    NUM_WIDTH = 2'd1,
    NUM_PREC  = 2'd2
  } num_mode_t;

  typedef enum logic [1:0] {
    PAIR_NONE = 2'd0,
    PAIR_H    = 2'd1,
    PAIR_L    = 2'd2
  } pair_t;

  typedef struct packed {
    logic        left;
    logic        zero;
    logic        plus;
    logic        space;
    logic        alt;
    logic        ldbl;
    logic [31:0] width;
    logic [31:0] prec;
    len_code_t   len;
    num_mode_t   num;
    pair_t       pair;
    logic        active;
  } psp_state_t;

  localparam psp_state_t STATE_RST = '{
    left: 1'b0, zero: 1'b0, plus: 1'b0, space: 1'b0, alt: 1'b0, ldbl: 1'b0,
    width: 32'h0, prec: PREC_NONE, len: LEN_NONE, num: NUM_OFF,
    pair: PAIR_NONE, active: 1'b0
  };

  // characters that close a specification
  function automatic logic is_ender(input logic [7:0] c);
    logic r;
    unique case (c)
      CH_LC, CH_LS, CH_LP, CH_LD, CH_LI, CH_LO, CH_LU, CH_LX, CH_UX, CH_LF,
      CH_US, CH_UC, CH_UZ, CH_PCT, CH_NUL: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // v*10 + d on the low 31 bits, saturating
  function automatic logic [31:0] grow(input logic [31:0] v, input logic [3:0] d);
    logic [34:0] r;
    r = ({4'b0, v[30:0]} << 3) + ({4'b0, v[30:0]} << 1) + {31'b0, d};
    return (r > {3'b0, NUM_MAX}) ? NUM_MAX : r[31:0];
  endfunction

endpackage

// File: hw/rtl/psp_step.sv
// ----------------------------------------------------------------------------
// psp_step
// next-state and termination logic for one format character
// ----------------------------------------------------------------------------
module psp_step (
  input  psp_pkg::psp_state_t cur,
  input  logic                start_req,
  input  logic [7:0]          ch,
  input  logic [31:0]         star_arg,
  output psp_pkg::psp_state_t nxt,
  output logic                done_res,
  output logic [7:0]          conv_char
);

  logic       is_digit;
  logic [7:0] dig_full;
  logic [3:0] dig;
  logic       handled;

  assign is_digit = (ch >= psp_pkg::CH_0) && (ch <= psp_pkg::CH_9);
  assign dig_full = ch - psp_pkg::CH_0;
  assign dig      = dig_full[3:0];

  always_comb begin
    nxt       = cur;
    done_res  = 1'b0;
    conv_char = psp_pkg::CH_NUL;
    handled   = 1'b0;
    if (start_req) begin
      nxt        = psp_pkg::STATE_RST;
      nxt.active = 1'b1;
    end else if (cur.active) begin
      // second letter of hh / ll
      if (cur.pair != psp_pkg::PAIR_NONE) begin
        nxt.pair = psp_pkg::PAIR_NONE;
        if (cur.pair == psp_pkg::PAIR_H && ch == psp_pkg::CH_LH) begin
          nxt.len = psp_pkg::LEN_HH;
          handled = 1'b1;
        end else if (cur.pair == psp_pkg::PAIR_L && ch == psp_pkg::CH_LL) begin
          nxt.len = psp_pkg::LEN_LL;
          handled = 1'b1;
        end
      end
      // digit continuing a number
      if (!handled && cur.num != psp_pkg::NUM_OFF) begin
        if (is_digit) begin
          if (cur.num == psp_pkg::NUM_WIDTH) begin
            nxt.width = psp_pkg::grow(cur.width, dig);
          end else begin
            nxt.prec = psp_pkg::grow(cur.prec, dig);
          end
          handled = 1'b1;
        end else begin
          nxt.num = psp_pkg::NUM_OFF;
        end
      end
      if (!handled) begin
        if (psp_pkg::is_ender(ch)) begin
          done_res   = 1'b1;
          conv_char  = ch;
          nxt.active = 1'b0;
        end else begin
          priority if (ch == psp_pkg::CH_SPACE) begin
            nxt.space = 1'b1;
          end else if (ch == psp_pkg::CH_HASH) begin
            nxt.alt = 1'b1;
          end else if (ch == psp_pkg::CH_LL && cur.len != psp_pkg::LEN_H &&
                       cur.len != psp_pkg::LEN_HH) begin
            nxt.len  = psp_pkg::LEN_L;
            nxt.pair = psp_pkg::PAIR_L;
          end else if (ch == psp_pkg::CH_UL) begin
            nxt.ldbl = 1'b1;
          end else if (ch == psp_pkg::CH_LH && cur.len != psp_pkg::LEN_L &&
                       cur.len != psp_pkg::LEN_LL) begin
            nxt.len  = psp_pkg::LEN_H;
            nxt.pair = psp_pkg::PAIR_H;
          end else if (ch == psp_pkg::CH_MINUS) begin
            nxt.left = 1'b1;
          end else if (ch == psp_pkg::CH_PLUS) begin
            nxt.plus = 1'b1;
          end else if (ch == psp_pkg::CH_0) begin
            nxt.zero = 1'b1;
          end else if (ch >= psp_pkg::CH_1 && ch <= psp_pkg::CH_9) begin
            nxt.width = {28'b0, dig};
            nxt.num   = psp_pkg::NUM_WIDTH;
          end else if (ch == psp_pkg::CH_DOT) begin
            nxt.prec = 32'h0;
            nxt.num  = psp_pkg::NUM_PREC;
          end else if (ch == psp_pkg::CH_STAR) begin
            nxt.width = star_arg;
          end else begin
            nxt = nxt; // unknown character, skipped
          end
        end
      end
    end
  end

endmodule

// File: hw/rtl/printf_spec_parser.sv
// ----------------------------------------------------------------------------
// printf_spec_parser
// streaming parser for one printf conversion specification per run of items
// ----------------------------------------------------------------------------
// one format character enters per transaction and exactly one result
// transaction leaves for each from a register; a new character is taken on
// every cycle while the result register is empty or being drained, so the
// sustained rate is one character per clock. the only loop is the parse state
// register fed back through a single step of decode logic (one digit times
// ten add with saturation). set in_tuser on the opening percent to clear all
// fields; out_tlast marks the character that closed the specification, and
// the conversion character is then reported with every parsed field. while a
// specification is open the fields show the values parsed so far; with no
// specification open characters are ignored. precision reads all ones when
// none was given.
module printf_spec_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // ch [7:0], star_arg [39:8]
  input  logic        in_tuser,   // start_req
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // conv_char [7:0], left_align [8], zero_pad [9],
                                  // plus_flag [10], space_flag [11], alt_form [12],
                                  // width [44:13], precision [76:45],
                                  // length_mod [79:77], long_double [80], zero fill
  output logic        out_tlast   // done_res
);

  psp_pkg::psp_state_t state_r;
  psp_pkg::psp_state_t state_nxt;
  logic                done_nxt;
  logic [7:0]          conv_nxt;
  logic                in_acc;

  logic                out_valid_r;
  logic [87:0]         out_data_r;
  logic                out_last_r;

  // accept whenever the result register is free or emptying this cycle
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  psp_step u_step (
    .cur       (state_r),
    .start_req (in_tuser),
    .ch        (in_tdata[7:0]),
    .star_arg  (in_tdata[39:8]),
    .nxt       (state_nxt),
    .done_res  (done_nxt),
    .conv_char (conv_nxt)
  );

  // parse state, advanced once per accepted character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psp_pkg::STATE_RST;
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_last_r <= done_nxt;
      out_data_r <= {7'b0, state_nxt.ldbl, state_nxt.len, state_nxt.prec,
                     state_nxt.width, state_nxt.alt, state_nxt.space,
                     state_nxt.plus, state_nxt.zero, state_nxt.left, conv_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
